>>> hw/rtl/boundary_tag_heap_allocator_unit_defines.svh
// Assertion macros shared by the checker of the heap allocator.
// No dependencies.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BTH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BTH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/bthalloc_pkg.sv
// Package of the heap allocator: sizes, header layout, codes and states.
// No dependencies.
`timescale 1ns / 1ps

package bthalloc_pkg;

   localparam int HEAP_GRANULES = 4096;
   localparam int GRANULE_BYTES = 8;
   localparam int GRANULE_SHIFT = $clog2(GRANULE_BYTES);
   localparam int ADDR_W        = $clog2(HEAP_GRANULES);
   localparam int SIZE_W        = ADDR_W + 1;
   localparam int END_W         = ADDR_W + 2;
   localparam int BYTES_W       = 16;
   localparam int NEED_W        = BYTES_W - GRANULE_SHIFT + 1;
   localparam int KIND_W        = 2;
   localparam int STATUS_W      = 3;
   localparam int TOTAL_W       = 13;

   typedef struct packed {
      logic              occ;
      logic [SIZE_W-1:0] size;
      logic [SIZE_W-1:0] prev;
   } hdr_type;

   localparam int HDR_W = $bits(hdr_type);

   typedef enum logic [KIND_W-1:0] {
      KIND_ALLOC = 2'd0,
      KIND_FREE  = 2'd1,
      KIND_CHECK = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_NO_FIT     = 3'd1,
      ST_FIRST_PREV = 3'd2,
      ST_OVERRUN    = 3'd3,
      ST_ADJ_FREE   = 3'd4,
      ST_PREV_LINK  = 3'd5,
      ST_NEXT_LINK  = 3'd6,
      ST_LAST_LINK  = 3'd7
   } status_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_A_RD,
      S_A_EV,
      S_F_RDH,
      S_F_CAPH,
      S_F_CAPN,
      S_F_CAPL,
      S_F_EV,
      S_C_RD0,
      S_C_CAP0,
      S_C_LOOP,
      S_C_CAPC,
      S_C_CAPA,
      S_C_LINK,
      S_C_CAPL,
      S_C_TALLY,
      S_W1,
      S_W2,
      S_FIX_RD,
      S_FIX_WR,
      S_RESP
   } state_type;

endpackage

>>> hw/rtl/bthalloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bthalloc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> hw/rtl/boundary_tag_heap_allocator_unit.sv
// Top level of the boundary-tag heap allocator: sequencer and header store.
// Depends on bthalloc_pkg and bthalloc_ram.
//
//   channel | direction | words
//   req_    | in        | kind, size_bytes, block_addr
//   rsp_    | out       | status, addr, four totals, fault_addr
//
// Allocate reads and tests one header per block visited, then writes the headers and result.
// Free reads three headers, then writes; check reads each block and its neighbour links.
// All accesses go through the single header RAM port pair.
// After reset the S_INIT state writes the initial free block before req_ready rises.
// A result waits in the output register while rsp_ready is low.
`timescale 1ns / 1ps

module boundary_tag_heap_allocator_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [bthalloc_pkg::KIND_W-1:0]        req_kind,
   input  logic [bthalloc_pkg::BYTES_W-1:0]       req_size_bytes,
   input  logic [bthalloc_pkg::ADDR_W-1:0]        req_block_addr,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [bthalloc_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bthalloc_pkg::ADDR_W-1:0]        rsp_addr,
   output logic [bthalloc_pkg::TOTAL_W-1:0]       rsp_used_granules,
   output logic [bthalloc_pkg::TOTAL_W-1:0]       rsp_free_granules,
   output logic [bthalloc_pkg::TOTAL_W-1:0]       rsp_occupied_total,
   output logic [bthalloc_pkg::TOTAL_W-1:0]       rsp_unoccupied_total,
   output logic [bthalloc_pkg::ADDR_W-1:0]        rsp_fault_addr
);
   import bthalloc_pkg::*;

   localparam logic [END_W-1:0] HEAP_END = END_W'(HEAP_GRANULES);
   localparam logic [ADDR_W-1:0] LAST_ITER = ADDR_W'(HEAP_GRANULES - 1);

   state_type state_ff, state_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [HDR_W-1:0]    ram_wdata, ram_rdata;
   hdr_type             rd;

   logic [NEED_W-1:0]   need_ff, need_in;
   logic [ADDR_W-1:0]   h_ff, h_in, start_ff, start_in, iter_ff, iter_in;
   logic [ADDR_W-1:0]   rov_ff, rov_in;
   hdr_type             hd_ff, hd_in, nd_ff, nd_in, ld_ff, ld_in, cd_ff, cd_in;
   logic [END_W-1:0]    cur_ff, cur_in, aft_ff, aft_in;
   logic [ADDR_W-1:0]   last_addr_ff, last_addr_in;
   logic                last_occ_ff, last_occ_in;
   logic [SIZE_W-1:0]   last_size_ff, last_size_in;
   logic [TOTAL_W-1:0]  used_ff, used_in, free_ff, free_in;
   logic [TOTAL_W-1:0]  occt_ff, occt_in, unocct_ff, unocct_in;
   logic                w1_en_ff, w1_en_in, w2_en_ff, w2_en_in, fix_en_ff, fix_en_in;
   logic [ADDR_W-1:0]   w1_addr_ff, w1_addr_in, w2_addr_ff, w2_addr_in;
   logic [ADDR_W-1:0]   fix_addr_ff, fix_addr_in;
   hdr_type             w1_data_ff, w1_data_in, w2_data_ff, w2_data_in;
   logic [SIZE_W-1:0]   fix_val_ff, fix_val_in;
   status_type          status_ff, status_in;
   logic [ADDR_W-1:0]   res_addr_ff, res_addr_in, fault_ff, fault_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in, rsp_fault_ff, rsp_fault_in;
   logic [TOTAL_W-1:0]  rsp_used_ff, rsp_used_in, rsp_free_ff, rsp_free_in;
   logic [TOTAL_W-1:0]  rsp_occt_ff, rsp_occt_in, rsp_unocct_ff, rsp_unocct_in;

   logic [END_W-1:0]    a_end, f_aft, f_aa, c_aft;
   logic                a_fit, f_has_next, f_has_prev;
   logic [SIZE_W-1:0]   a_left;
   logic [ADDR_W-1:0]   a_next, f_last;

   bthalloc_ram #(
      .WIDTH(HDR_W),
      .DEPTH(HEAP_GRANULES)
   ) u_hdr_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rd = hdr_type'(ram_rdata);

   assign a_end  = END_W'(h_ff) + END_W'(rd.size) + END_W'(1);
   assign a_fit  = !rd.occ && (a_end <= HEAP_END) && (NEED_W'(rd.size) >= need_ff);
   assign a_left = rd.size - SIZE_W'(need_ff);
   assign a_next = (a_end >= HEAP_END) ? '0 : a_end[ADDR_W-1:0];

   assign f_aft      = END_W'(h_ff) + END_W'(hd_ff.size) + END_W'(1);
   assign f_has_next = f_aft < HEAP_END;
   assign f_has_prev = (hd_ff.prev != '0) &&
                       (END_W'(hd_ff.prev) + END_W'(1) <= END_W'(h_ff));
   assign f_last     = h_ff - ADDR_W'(hd_ff.prev) - ADDR_W'(1);
   assign f_aa       = f_aft + END_W'(nd_ff.size) + END_W'(1);

   assign c_aft = cur_ff + END_W'(rd.size) + END_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rov_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rov_ff       <= rov_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff       <= need_in;
      h_ff          <= h_in;
      start_ff      <= start_in;
      iter_ff       <= iter_in;
      hd_ff         <= hd_in;
      nd_ff         <= nd_in;
      ld_ff         <= ld_in;
      cd_ff         <= cd_in;
      cur_ff        <= cur_in;
      aft_ff        <= aft_in;
      last_addr_ff  <= last_addr_in;
      last_occ_ff   <= last_occ_in;
      last_size_ff  <= last_size_in;
      used_ff       <= used_in;
      free_ff       <= free_in;
      occt_ff       <= occt_in;
      unocct_ff     <= unocct_in;
      w1_en_ff      <= w1_en_in;
      w2_en_ff      <= w2_en_in;
      fix_en_ff     <= fix_en_in;
      w1_addr_ff    <= w1_addr_in;
      w2_addr_ff    <= w2_addr_in;
      fix_addr_ff   <= fix_addr_in;
      w1_data_ff    <= w1_data_in;
      w2_data_ff    <= w2_data_in;
      fix_val_ff    <= fix_val_in;
      status_ff     <= status_in;
      res_addr_ff   <= res_addr_in;
      fault_ff      <= fault_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_fault_ff  <= rsp_fault_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_occt_ff   <= rsp_occt_in;
      rsp_unocct_ff <= rsp_unocct_in;
   end

   always_comb begin
      state_in      = state_ff;
      need_in       = need_ff;
      h_in          = h_ff;
      start_in      = start_ff;
      iter_in       = iter_ff;
      rov_in        = rov_ff;
      hd_in         = hd_ff;
      nd_in         = nd_ff;
      ld_in         = ld_ff;
      cd_in         = cd_ff;
      cur_in        = cur_ff;
      aft_in        = aft_ff;
      last_addr_in  = last_addr_ff;
      last_occ_in   = last_occ_ff;
      last_size_in  = last_size_ff;
      used_in       = used_ff;
      free_in       = free_ff;
      occt_in       = occt_ff;
      unocct_in     = unocct_ff;
      w1_en_in      = w1_en_ff;
      w2_en_in      = w2_en_ff;
      fix_en_in     = fix_en_ff;
      w1_addr_in    = w1_addr_ff;
      w2_addr_in    = w2_addr_ff;
      fix_addr_in   = fix_addr_ff;
      w1_data_in    = w1_data_ff;
      w2_data_in    = w2_data_ff;
      fix_val_in    = fix_val_ff;
      status_in     = status_ff;
      res_addr_in   = res_addr_ff;
      fault_in      = fault_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_fault_in  = rsp_fault_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_occt_in   = rsp_occt_ff;
      rsp_unocct_in = rsp_unocct_ff;
      ram_we        = 1'b0;
      ram_waddr     = w1_addr_ff;
      ram_wdata     = w1_data_ff;
      ram_raddr     = h_ff;
      req_ready     = 1'b0;

      case (state_ff)
         S_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {1'b0, SIZE_W'(HEAP_GRANULES - 1), SIZE_W'(0)};
            state_in  = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               status_in   = ST_OK;
               res_addr_in = '0;
               fault_in    = '0;
               used_in     = '0;
               free_in     = '0;
               occt_in     = '0;
               unocct_in   = '0;
               w1_en_in    = 1'b0;
               w2_en_in    = 1'b0;
               fix_en_in   = 1'b0;
               state_in    = S_RESP;
               case (kind_type'(req_kind))
                  KIND_ALLOC: begin
                     need_in  = NEED_W'((17'(req_size_bytes) + 17'(GRANULE_BYTES - 1))
                                >> GRANULE_SHIFT);
                     h_in     = rov_ff;
                     start_in = rov_ff;
                     iter_in  = '0;
                     if (req_size_bytes == '0) begin
                        status_in = ST_NO_FIT;
                     end else begin
                        state_in = S_A_RD;
                     end
                  end
                  KIND_FREE: begin
                     h_in = req_block_addr - ADDR_W'(1);
                     if (req_block_addr != '0) begin
                        state_in = S_F_RDH;
                     end
                  end
                  KIND_CHECK: begin
                     state_in = S_C_RD0;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_A_RD: begin
            ram_raddr = h_ff;
            state_in  = S_A_EV;
         end
         S_A_EV: begin
            if (a_fit) begin
               res_addr_in = h_ff + ADDR_W'(1);
               state_in    = S_W1;
               w1_en_in    = 1'b1;
               if (a_left < SIZE_W'(2)) begin
                  w1_addr_in = h_ff;
                  w1_data_in = {1'b1, rd.size, rd.prev};
                  rov_in     = a_next;
               end else begin
                  w1_addr_in  = h_ff + ADDR_W'(1) + ADDR_W'(need_ff);
                  w1_data_in  = {1'b0, a_left - SIZE_W'(1), SIZE_W'(need_ff)};
                  w2_en_in    = 1'b1;
                  w2_addr_in  = h_ff;
                  w2_data_in  = {1'b1, SIZE_W'(need_ff), rd.prev};
                  fix_en_in   = a_end < HEAP_END;
                  fix_addr_in = a_end[ADDR_W-1:0];
                  fix_val_in  = a_left - SIZE_W'(1);
                  rov_in      = h_ff + ADDR_W'(1) + ADDR_W'(need_ff);
               end
            end else if (a_next == start_ff || iter_ff == LAST_ITER) begin
               status_in = ST_NO_FIT;
               state_in  = S_RESP;
            end else begin
               h_in     = a_next;
               iter_in  = iter_ff + ADDR_W'(1);
               state_in = S_A_RD;
            end
         end
         S_F_RDH: begin
            ram_raddr = h_ff;
            state_in  = S_F_CAPH;
         end
         S_F_CAPH: begin
            hd_in     = rd;
            ram_raddr = h_ff + ADDR_W'(rd.size) + ADDR_W'(1);
            state_in  = S_F_CAPN;
         end
         S_F_CAPN: begin
            nd_in     = rd;
            ram_raddr = f_last;
            state_in  = S_F_CAPL;
         end
         S_F_CAPL: begin
            ld_in    = rd;
            state_in = S_F_EV;
         end
         S_F_EV: begin
            state_in    = S_W1;
            w1_en_in    = 1'b1;
            w1_addr_in  = h_ff;
            w1_data_in  = {1'b0, hd_ff.size, hd_ff.prev};
            fix_addr_in = f_aa[ADDR_W-1:0];
            if (f_has_next && !nd_ff.occ &&
                (!f_has_prev || ld_ff.occ)) begin
               w1_data_in = {1'b0, hd_ff.size + nd_ff.size + SIZE_W'(1), hd_ff.prev};
               fix_en_in  = f_aa < HEAP_END;
               fix_val_in = hd_ff.size + nd_ff.size + SIZE_W'(1);
               if (rov_ff == f_aft[ADDR_W-1:0]) begin
                  rov_in = h_ff;
               end
            end else if (f_has_prev && !ld_ff.occ) begin
               w1_addr_in = f_last;
               if (f_has_next && !nd_ff.occ) begin
                  w1_data_in = {ld_ff.occ,
                                ld_ff.size + hd_ff.size + nd_ff.size + SIZE_W'(2),
                                ld_ff.prev};
                  fix_en_in  = f_aa < HEAP_END;
                  fix_val_in = ld_ff.size + hd_ff.size + nd_ff.size + SIZE_W'(2);
                  if (rov_ff == h_ff || rov_ff == f_aft[ADDR_W-1:0]) begin
                     rov_in = f_last;
                  end
               end else begin
                  w1_data_in = {ld_ff.occ, ld_ff.size + hd_ff.size + SIZE_W'(1),
                                ld_ff.prev};
                  if (f_has_next) begin
                     w2_en_in   = 1'b1;
                     w2_addr_in = f_aft[ADDR_W-1:0];
                     w2_data_in = {nd_ff.occ, nd_ff.size,
                                   ld_ff.size + hd_ff.size + SIZE_W'(1)};
                  end
                  if (rov_ff == h_ff) begin
                     rov_in = f_last;
                  end
               end
            end
         end
         S_C_RD0: begin
            ram_raddr = '0;
            state_in  = S_C_CAP0;
         end
         S_C_CAP0: begin
            last_addr_in = '0;
            last_occ_in  = rd.occ;
            last_size_in = rd.size;
            cur_in       = END_W'(rd.size) + END_W'(1);
            if (rd.occ) begin
               used_in = TOTAL_W'(rd.size);
               occt_in = TOTAL_W'(rd.size) + TOTAL_W'(1);
            end else begin
               free_in   = TOTAL_W'(rd.size);
               unocct_in = TOTAL_W'(rd.size) + TOTAL_W'(1);
            end
            if (rd.prev != '0) begin
               status_in = ST_FIRST_PREV;
               state_in  = S_RESP;
            end else begin
               state_in = S_C_LOOP;
            end
         end
         S_C_LOOP: begin
            ram_raddr = cur_ff[ADDR_W-1:0];
            if (cur_ff == HEAP_END) begin
               state_in = S_RESP;
            end else if (cur_ff > HEAP_END) begin
               status_in = ST_OVERRUN;
               fault_in  = cur_ff[ADDR_W-1:0];
               state_in  = S_RESP;
            end else begin
               state_in = S_C_CAPC;
            end
         end
         S_C_CAPC: begin
            cd_in     = rd;
            aft_in    = c_aft;
            ram_raddr = c_aft[ADDR_W-1:0];
            state_in  = (c_aft < HEAP_END) ? S_C_CAPA : S_C_LINK;
         end
         S_C_CAPA: begin
            if (rd.prev != cd_ff.size) begin
               status_in = ST_NEXT_LINK;
               fault_in  = cur_ff[ADDR_W-1:0];
               state_in  = S_RESP;
            end else begin
               state_in = S_C_LINK;
            end
         end
         S_C_LINK: begin
            ram_raddr = cur_ff[ADDR_W-1:0] - ADDR_W'(cd_ff.prev) - ADDR_W'(1);
            if (cd_ff.prev == '0) begin
               state_in = S_C_TALLY;
            end else if (END_W'(cd_ff.prev) + END_W'(1) > cur_ff) begin
               status_in = ST_PREV_LINK;
               fault_in  = cur_ff[ADDR_W-1:0];
               state_in  = S_RESP;
            end else begin
               last_addr_in = cur_ff[ADDR_W-1:0] - ADDR_W'(cd_ff.prev) - ADDR_W'(1);
               state_in     = S_C_CAPL;
            end
         end
         S_C_CAPL: begin
            last_occ_in  = rd.occ;
            last_size_in = rd.size;
            if (rd.size != cd_ff.prev) begin
               status_in = ST_PREV_LINK;
               fault_in  = cur_ff[ADDR_W-1:0];
               state_in  = S_RESP;
            end else begin
               state_in = S_C_TALLY;
            end
         end
         S_C_TALLY: begin
            if (!cd_ff.occ && !last_occ_ff) begin
               status_in = ST_ADJ_FREE;
               fault_in  = last_addr_ff;
               state_in  = S_RESP;
            end else begin
               if (cd_ff.occ) begin
                  used_in = used_ff + TOTAL_W'(cd_ff.size);
                  occt_in = occt_ff + TOTAL_W'(cd_ff.size) + TOTAL_W'(1);
               end else begin
                  free_in   = free_ff + TOTAL_W'(cd_ff.size);
                  unocct_in = unocct_ff + TOTAL_W'(cd_ff.size) + TOTAL_W'(1);
               end
               if (last_size_ff != cd_ff.prev) begin
                  status_in = ST_LAST_LINK;
                  fault_in  = last_addr_ff;
                  state_in  = S_RESP;
               end else begin
                  last_addr_in = cur_ff[ADDR_W-1:0];
                  last_occ_in  = cd_ff.occ;
                  last_size_in = cd_ff.size;
                  cur_in       = aft_ff;
                  state_in     = S_C_LOOP;
               end
            end
         end
         S_W1: begin
            ram_we    = w1_en_ff;
            ram_waddr = w1_addr_ff;
            ram_wdata = w1_data_ff;
            state_in  = S_W2;
         end
         S_W2: begin
            ram_we    = w2_en_ff;
            ram_waddr = w2_addr_ff;
            ram_wdata = w2_data_ff;
            state_in  = fix_en_ff ? S_FIX_RD : S_RESP;
         end
         S_FIX_RD: begin
            ram_raddr = fix_addr_ff;
            state_in  = S_FIX_WR;
         end
         S_FIX_WR: begin
            ram_we    = 1'b1;
            ram_waddr = fix_addr_ff;
            ram_wdata = {rd.occ, rd.size, fix_val_ff};
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = res_addr_ff;
               rsp_fault_in  = fault_ff;
               rsp_used_in   = used_ff;
               rsp_free_in   = free_ff;
               rsp_occt_in   = occt_ff;
               rsp_unocct_in = unocct_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_addr             = rsp_addr_ff;
   assign rsp_used_granules    = rsp_used_ff;
   assign rsp_free_granules    = rsp_free_ff;
   assign rsp_occupied_total   = rsp_occt_ff;
   assign rsp_unoccupied_total = rsp_unocct_ff;
   assign rsp_fault_addr       = rsp_fault_ff;

endmodule

>>> hw/rtl/bthalloc_checker.sv
// Port-level checker of the heap allocator, bound to the top level.
// Depends on bthalloc_pkg and the defines header.
`timescale 1ns / 1ps
`include "boundary_tag_heap_allocator_unit_defines.svh"

module bthalloc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [bthalloc_pkg::STATUS_W-1:0]   rsp_status,
   input logic [bthalloc_pkg::ADDR_W-1:0]     rsp_addr,
   input logic [bthalloc_pkg::TOTAL_W-1:0]    rsp_used_granules,
   input logic [bthalloc_pkg::TOTAL_W-1:0]    rsp_free_granules
);
   import bthalloc_pkg::*;

   `BTH_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready stayed high after a word was accepted")
   `BTH_ASSERT_IMPLY(a_addr_only_on_ok, clock, reset, rsp_valid && rsp_addr != '0, rsp_status == ST_OK, "address given with a failing status")
   `BTH_ASSERT_IMPLY(a_alloc_no_totals, clock, reset, rsp_valid && rsp_addr != '0, rsp_used_granules == '0 && rsp_free_granules == '0, "totals given with an allocation")
   `BTH_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_addr), "result word changed while stalled")

endmodule

bind boundary_tag_heap_allocator_unit bthalloc_checker u_bthalloc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_status(rsp_status),
   .rsp_addr(rsp_addr),
   .rsp_used_granules(rsp_used_granules),
   .rsp_free_granules(rsp_free_granules)
);

>>> tb/boundary_tag_heap_allocator_unit_tb.sv
// Self-checking testbench for the boundary-tag heap allocator: a heap shadow
// predicts every response word, driven through the req_/rsp_ handshakes.
// Depends on bthalloc_pkg and boundary_tag_heap_allocator_unit.
`timescale 1ns / 1ps

import bthalloc_pkg::*;

typedef struct {
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   addr;
   logic [TOTAL_W-1:0]  used;
   logic [TOTAL_W-1:0]  free;
   logic [TOTAL_W-1:0]  occ_total;
   logic [TOTAL_W-1:0]  unocc_total;
   logic [ADDR_W-1:0]   fault;
} heap_rsp_type;

class heap_scoreboard;
   logic              occ_q  [HEAP_GRANULES];
   logic [SIZE_W-1:0] size_q [HEAP_GRANULES];
   logic [SIZE_W-1:0] prev_q [HEAP_GRANULES];
   int                rover;
   heap_rsp_type      awaited[$];
   int                errors;

   function new();
      foreach (occ_q[i]) begin
         occ_q[i] = 0;
         size_q[i] = 0;
         prev_q[i] = 0;
      end
      size_q[0] = SIZE_W'(HEAP_GRANULES - 1);
      rover = 0;
      errors = 0;
   endfunction

   function void merge_after(int h, int ts, int aft);
      int aa;
      if (rover == aft) rover = h;
      size_q[h] = SIZE_W'(ts + size_q[aft] + 1);
      occ_q[h] = 0;
      aa = aft + size_q[aft] + 1;
      if (aa < HEAP_GRANULES) prev_q[aa] = size_q[h];
   endfunction

   function logic [STATUS_W-1:0] carve(int bytes, output int addr);
      int need, start, h, s, fin, nb;
      addr = 0;
      if (bytes == 0) return ST_NO_FIT;
      need = (bytes + GRANULE_BYTES - 1) / GRANULE_BYTES;
      start = (rover < HEAP_GRANULES) ? rover : 0;
      h = start;
      for (int it = 0; it < HEAP_GRANULES; it++) begin
         s = size_q[h];
         fin = h + s + 1;
         if (!occ_q[h] && fin <= HEAP_GRANULES && s >= need) begin
            if (s - need < 2) begin
               occ_q[h] = 1;
               rover = (fin == HEAP_GRANULES) ? 0 : fin;
            end else begin
               nb = h + 1 + need;
               size_q[nb] = SIZE_W'(s - need - 1);
               prev_q[nb] = SIZE_W'(need);
               occ_q[nb] = 0;
               size_q[h] = SIZE_W'(need);
               occ_q[h] = 1;
               if (fin < HEAP_GRANULES) prev_q[fin] = SIZE_W'(s - need - 1);
               rover = nb;
            end
            addr = h + 1;
            return ST_OK;
         end
         h = (fin >= HEAP_GRANULES) ? 0 : fin;
         if (h == start) break;
      end
      return ST_NO_FIT;
   endfunction

   function void release_block(int a);
      int h, pv, last, ts, aft, aa;
      bit has_next, has_prev, lo, ao;
      last = 0;
      if (a == 0) return;
      h = a - 1;
      if (h >= HEAP_GRANULES) return;
      ts = size_q[h];
      aft = h + ts + 1;
      has_next = aft < HEAP_GRANULES;
      pv = prev_q[h];
      has_prev = pv != 0 && pv + 1 <= h;
      if (has_prev) last = h - pv - 1;
      if (!has_prev) begin
         if (has_next && !occ_q[aft]) merge_after(h, ts, aft);
         else occ_q[h] = 0;
         return;
      end
      if (has_next) begin
         lo = occ_q[last];
         ao = occ_q[aft];
         if (lo && ao) begin
            occ_q[h] = 0;
         end else if (lo) begin
            merge_after(h, ts, aft);
         end else if (ao) begin
            if (rover == h) rover = last;
            size_q[last] = SIZE_W'(size_q[last] + ts + 1);
            prev_q[aft] = size_q[last];
         end else begin
            aa = aft + size_q[aft] + 1;
            if (rover == h || rover == aft) rover = last;
            size_q[last] = SIZE_W'(size_q[last] + ts + size_q[aft] + 2);
            if (aa < HEAP_GRANULES) prev_q[aa] = size_q[last];
         end
      end else begin
         if (occ_q[last]) begin
            occ_q[h] = 0;
         end else begin
            if (rover == h) rover = last;
            size_q[last] = SIZE_W'(size_q[last] + ts + 1);
         end
      end
   endfunction

   function void count_block(int h, ref int t[4]);
      if (occ_q[h]) begin
         t[0] += size_q[h];
         t[2] += size_q[h] + 1;
      end else begin
         t[1] += size_q[h];
         t[3] += size_q[h] + 1;
      end
   endfunction

   function logic [STATUS_W-1:0] audit(ref int t[4], output int fault);
      int last, cur, c, ts, aft;
      last = 0;
      fault = 0;
      count_block(0, t);
      if (prev_q[0] != 0) return ST_FIRST_PREV;
      cur = size_q[0] + 1;
      while (cur != HEAP_GRANULES) begin
         if (cur > HEAP_GRANULES) begin
            fault = cur;
            return ST_OVERRUN;
         end
         c = cur;
         ts = size_q[c];
         aft = cur + ts + 1;
         if (aft < HEAP_GRANULES && prev_q[aft] != ts) begin
            fault = c;
            return ST_NEXT_LINK;
         end
         if (prev_q[c] != 0) begin
            if (prev_q[c] + 1 > c) begin
               fault = c;
               return ST_PREV_LINK;
            end
            last = c - prev_q[c] - 1;
            if (size_q[last] != prev_q[c]) begin
               fault = c;
               return ST_PREV_LINK;
            end
         end
         if (!occ_q[c] && !occ_q[last]) begin
            fault = last;
            return ST_ADJ_FREE;
         end
         count_block(c, t);
         if (size_q[last] != prev_q[c]) begin
            fault = last;
            return ST_LAST_LINK;
         end
         last = c;
         cur = aft;
      end
      return ST_OK;
   endfunction

   // Returns the payload address handed out, or 0.
   function int note_request(kind_type kind, int bytes, int baddr);
      heap_rsp_type r;
      int t[4];
      int a, f;
      t = '{0, 0, 0, 0};
      a = 0;
      f = 0;
      r.status = ST_OK;
      case (kind)
         KIND_ALLOC: r.status = carve(bytes, a);
         KIND_FREE:  release_block(baddr);
         KIND_CHECK: r.status = audit(t, f);
         default:    ;
      endcase
      r.addr = ADDR_W'(a);
      r.used = TOTAL_W'(t[0]);
      r.free = TOTAL_W'(t[1]);
      r.occ_total = TOTAL_W'(t[2]);
      r.unocc_total = TOTAL_W'(t[3]);
      r.fault = ADDR_W'(f);
      awaited.push_back(r);
      return a;
   endfunction

   function int free_header();
      int cur, found[$];
      cur = 0;
      while (cur < HEAP_GRANULES) begin
         if (!occ_q[cur]) found.push_back(cur);
         cur += size_q[cur] + 1;
      end
      if (found.size() == 0) return -1;
      return found[$urandom_range(found.size() - 1)];
   endfunction

   function void check_response(heap_rsp_type got);
      heap_rsp_type e;
      if (awaited.size() == 0) begin
         $display("%0t: unexpected response word, status %0d", $time, got.status);
         errors++;
         return;
      end
      e = awaited.pop_front();
      if (got.status !== e.status) begin
         $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
         errors++;
      end
      if (got.addr !== e.addr) begin
         $display("%0t: addr exp %0d got %0d", $time, e.addr, got.addr);
         errors++;
      end
      if (got.used !== e.used) begin
         $display("%0t: used exp %0d got %0d", $time, e.used, got.used);
         errors++;
      end
      if (got.free !== e.free) begin
         $display("%0t: free exp %0d got %0d", $time, e.free, got.free);
         errors++;
      end
      if (got.occ_total !== e.occ_total) begin
         $display("%0t: occupied exp %0d got %0d", $time, e.occ_total, got.occ_total);
         errors++;
      end
      if (got.unocc_total !== e.unocc_total) begin
         $display("%0t: unoccupied exp %0d got %0d", $time, e.unocc_total,
                  got.unocc_total);
         errors++;
      end
      if (got.fault !== e.fault) begin
         $display("%0t: fault exp %0d got %0d", $time, e.fault, got.fault);
         errors++;
      end
   endfunction
endclass

module boundary_tag_heap_allocator_unit_tb;
   localparam int RANDOM_ITEMS = 1350;
   localparam int CALM_ITEMS   = 200;
   localparam int STALL_LIMIT  = 200000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind;
   logic [BYTES_W-1:0]  req_size_bytes;
   logic [ADDR_W-1:0]   req_block_addr;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [STATUS_W-1:0] rsp_status;
   logic [ADDR_W-1:0]   rsp_addr;
   logic [TOTAL_W-1:0]  rsp_used_granules;
   logic [TOTAL_W-1:0]  rsp_free_granules;
   logic [TOTAL_W-1:0]  rsp_occupied_total;
   logic [TOTAL_W-1:0]  rsp_unoccupied_total;
   logic [ADDR_W-1:0]   rsp_fault_addr;

   heap_scoreboard sb = new();
   int             live[$];
   bit             stalls_on;
   int             quiet_cycles;
   int             hold_cnt;

   boundary_tag_heap_allocator_unit u_dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      heap_rsp_type got;
      if (reset) begin
         rsp_ready <= 0;
         hold_cnt = 0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.addr = rsp_addr;
            got.used = rsp_used_granules;
            got.free = rsp_free_granules;
            got.occ_total = rsp_occupied_total;
            got.unocc_total = rsp_unoccupied_total;
            got.fault = rsp_fault_addr;
            sb.check_response(got);
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("** boundary_tag_heap_allocator_unit: FAILED **");
            $finish;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 0;
         end else if (stalls_on && $urandom_range(7) == 0) begin
            hold_cnt = $urandom_range(12, 1) - 1;
            rsp_ready <= 0;
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   task automatic send_item(kind_type kind, int bytes, int baddr);
      int a;
      if (stalls_on && $urandom_range(5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(12, 1)) @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_size_bytes <= BYTES_W'(bytes);
      req_block_addr <= ADDR_W'(baddr);
      do @(posedge clock); while (!req_ready);
      a = sb.note_request(kind, bytes, baddr);
      if (kind == KIND_ALLOC && a != 0) live.push_back(a);
   endtask

   task automatic free_live();
      int i, a;
      i = $urandom_range(live.size() - 1);
      a = live[i];
      live.delete(i);
      send_item(KIND_FREE, 0, a);
   endtask

   task automatic random_item();
      int p, h, bytes;
      p = $urandom_range(99);
      if (p < 45 || (p < 85 && live.size() == 0)) begin
         h = $urandom_range(99);
         if (h < 85) bytes = $urandom_range(64, 1);
         else if (h < 95) bytes = $urandom_range(2048, 65);
         else bytes = $urandom_range(32768, 2049);
         send_item(KIND_ALLOC, bytes, $urandom_range(4095));
      end else if (p < 85) begin
         free_live();
      end else if (p < 95) begin
         send_item(KIND_CHECK, $urandom_range(32768), $urandom_range(4095));
      end else if (p < 97) begin
         send_item(KIND_NONE, $urandom_range(32768), $urandom_range(4095));
      end else if (p < 98) begin
         send_item(KIND_FREE, $urandom_range(32768), 0);
      end else begin
         h = sb.free_header();
         if (h >= 0) send_item(KIND_FREE, 0, h + 1);
         else send_item(KIND_ALLOC, 0, 0);
      end
   endtask

   initial begin
      int waited;
      reset = 1;
      req_valid = 0;
      req_kind = KIND_ALLOC;
      req_size_bytes = 0;
      req_block_addr = 0;
      rsp_ready = 0;
      stalls_on = 1;
      repeat (9) @(posedge clock);
      reset <= 0;

      send_item(KIND_CHECK, 0, 0);
      send_item(KIND_ALLOC, 0, 0);
      send_item(KIND_ALLOC, 32768, 0);
      send_item(KIND_ALLOC, 32760, 0);
      send_item(KIND_CHECK, 0, 0);
      free_live();
      send_item(KIND_ALLOC, 32744, 0);
      send_item(KIND_CHECK, 0, 0);
      free_live();
      send_item(KIND_ALLOC, 32752, 0);
      free_live();
      send_item(KIND_FREE, 16'hFFFF, 0);
      send_item(KIND_NONE, 16'hFFFF, 12'hFFF);
      for (int i = 0; i < 6; i++) send_item(KIND_ALLOC, 8 * i + 1, 0);
      send_item(KIND_FREE, 0, live[1]);
      send_item(KIND_FREE, 0, live[2]);
      send_item(KIND_FREE, 0, live[4]);
      send_item(KIND_FREE, 0, live[3]);
      send_item(KIND_CHECK, 0, 0);
      live.delete(4);
      live.delete(3);
      live.delete(2);
      live.delete(1);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS) stalls_on = 0;
         random_item();
      end
      send_item(KIND_CHECK, 0, 0);
      req_valid <= 0;

      waited = 0;
      while (sb.awaited.size() != 0 && waited < STALL_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("** boundary_tag_heap_allocator_unit: PASSED **");
      else
         $display("** boundary_tag_heap_allocator_unit: FAILED **");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/bthalloc_pkg.sv
hw/rtl/bthalloc_ram.sv
hw/rtl/boundary_tag_heap_allocator_unit.sv
hw/rtl/bthalloc_checker.sv
tb/boundary_tag_heap_allocator_unit_tb.sv
